// ----- src/stake_weighted_leader_pick_core_assert.svh -----
// Assertion helpers used by the leader pick datapath.
`ifndef STAKE_WEIGHTED_LEADER_PICK_CORE_ASSERT_SVH
`define STAKE_WEIGHTED_LEADER_PICK_CORE_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define SWLP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold on every clock edge outside reset.
`define SWLP_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error(msg);

`endif

// ----- src/swlp_pkg.sv -----
package swlp_pkg;

  // Field widths.
  localparam int ID_W       = 16;
  localparam int AMT_W      = 32;
  localparam int STAKE_W    = 40;
  localparam int IN_DATA_W  = 88;
  localparam int OUT_DATA_W = 96;

  localparam logic [STAKE_W-1:0] STAKE_MAX = {STAKE_W{1'b1}};

  // Result status codes.
  localparam logic [1:0] STS_OK    = 2'd0;
  localparam logic [1:0] STS_FULL  = 2'd1;
  localparam logic [1:0] STS_EMPTY = 2'd2;
  localparam logic [1:0] STS_SAT   = 2'd3;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_UPDATE,
    ST_INSERT,
    ST_DONE
  } state_t;

  // Datapath commands issued by the controller.
  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SCAN,
    CMD_SHIFT,
    CMD_UPDATE,
    CMD_INSERT,
    CMD_EMIT
  } cmd_t;

  // Datapath status seen by the controller.
  typedef struct packed {
    logic is_pick;
    logic scan_stop;
    logic scan_match;
    logic full;
    logic shift_done;
    logic out_free;
  } dp_sts_t;

endpackage

// ----- src/swlp_ctrl.sv -----
module swlp_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  swlp_pkg::dp_sts_t sts,
  output swlp_pkg::cmd_t   cmd
);

  swlp_pkg::state_t state_r;
  swlp_pkg::state_t state_nxt;

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= swlp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      swlp_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = swlp_pkg::ST_SCAN;
        end
      end
      swlp_pkg::ST_SCAN: begin
        if (sts.scan_stop) begin
          if (sts.is_pick) begin
            state_nxt = swlp_pkg::ST_DONE;
          end else if (sts.scan_match) begin
            state_nxt = swlp_pkg::ST_UPDATE;
          end else if (sts.full) begin
            state_nxt = swlp_pkg::ST_DONE;
          end else begin
            state_nxt = swlp_pkg::ST_SHIFT;
          end
        end
      end
      swlp_pkg::ST_SHIFT: begin
        if (sts.shift_done) begin
          state_nxt = swlp_pkg::ST_INSERT;
        end
      end
      swlp_pkg::ST_UPDATE: state_nxt = swlp_pkg::ST_DONE;
      swlp_pkg::ST_INSERT: state_nxt = swlp_pkg::ST_DONE;
      swlp_pkg::ST_DONE: begin
        if (sts.out_free) begin
          state_nxt = swlp_pkg::ST_IDLE;
        end
      end
      default: state_nxt = swlp_pkg::ST_IDLE;
    endcase
  end

  // Command decode.
  always_comb begin
    cmd       = swlp_pkg::CMD_NONE;
    in_tready = 1'b0;
    case (state_r)
      swlp_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd = swlp_pkg::CMD_LOAD;
        end
      end
      swlp_pkg::ST_SCAN:   cmd = swlp_pkg::CMD_SCAN;
      swlp_pkg::ST_SHIFT:  cmd = swlp_pkg::CMD_SHIFT;
      swlp_pkg::ST_UPDATE: cmd = swlp_pkg::CMD_UPDATE;
      swlp_pkg::ST_INSERT: cmd = swlp_pkg::CMD_INSERT;
      swlp_pkg::ST_DONE: begin
        if (sts.out_free) begin
          cmd = swlp_pkg::CMD_EMIT;
        end
      end
      default: cmd = swlp_pkg::CMD_NONE;
    endcase
  end

endmodule

// ----- src/swlp_dp.sv -----
`include "stake_weighted_leader_pick_core_assert.svh"

module swlp_dp #(
  parameter int MAX_LEADERS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  swlp_pkg::cmd_t                      cmd,
  input  logic                                in_mode,
  input  logic [swlp_pkg::ID_W-1:0]           in_id,
  input  logic [swlp_pkg::AMT_W-1:0]          in_amt,
  input  logic [swlp_pkg::STAKE_W-1:0]        in_val,
  input  logic                                out_tready,
  output logic                                out_tvalid,
  output logic [swlp_pkg::OUT_DATA_W-1:0]     out_tdata,
  output swlp_pkg::dp_sts_t                   sts
);

  localparam int N     = MAX_LEADERS;
  localparam int AW    = $clog2(N);
  localparam int CW    = $clog2(N + 1);
  localparam int SUM_W = swlp_pkg::STAKE_W + $clog2(N);
  localparam int SW    = swlp_pkg::STAKE_W;
  localparam int IW    = swlp_pkg::ID_W;
  localparam int PAD_W = swlp_pkg::OUT_DATA_W - (3 * IW + SW + 2);

  // Leader table, kept in ascending id order.
  logic [IW-1:0] mem_id    [N];
  logic [SW-1:0] mem_stake [N];

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [IW-1:0] wr_id;
  logic [SW-1:0] wr_stake;
  logic [IW-1:0] rd_id_r;
  logic [SW-1:0] rd_stake_r;

  // Table state.
  logic [CW-1:0]    count_r, count_nxt;
  logic [SUM_W-1:0] total_r, total_nxt;
  logic             any_r, any_nxt;
  logic [IW-1:0]    first_r, first_nxt;
  logic [IW-1:0]    last_r, last_nxt;

  // Item and walk state.
  logic                     mode_r, mode_nxt;
  logic [IW-1:0]            id_r, id_nxt;
  logic [swlp_pkg::AMT_W-1:0] amt_r, amt_nxt;
  logic [SW-1:0]            val_r, val_nxt;
  logic [CW-1:0]            idx_r, idx_nxt;
  logic [CW-1:0]            pos_r, pos_nxt;
  logic [CW-1:0]            ins_r, ins_nxt;
  logic                     vld_r, vld_nxt;
  logic [SUM_W-1:0]         start_r, start_nxt;
  logic [IW-1:0]            seen_r, seen_nxt;
  logic [IW-1:0]            chosen_r, chosen_nxt;
  logic [1:0]               status_r, status_nxt;

  // Result register.
  logic                            out_valid_r, out_valid_nxt;
  logic [swlp_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  // Derived values.
  logic             full;
  logic             scan_hit;
  logic             scan_match;
  logic             scan_end;
  logic             scan_stop;
  logic             shift_done;
  logic [SUM_W-1:0] pick_end_sum;
  logic             pick_hit;
  logic [SW:0]      upd_sum;
  logic             upd_sat;
  logic [SW-1:0]    upd_stake;
  logic [SW-1:0]    upd_delta;
  logic [CW-1:0]    pos_inc;
  logic [CW-1:0]    idx_dec;
  logic [SW-1:0]    total_sat;
  logic             leader_up;

  // Table memory with registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_id[wr_addr]    <= wr_id;
      mem_stake[wr_addr] <= wr_stake;
    end
    if (rd_en) begin
      rd_id_r    <= mem_id[rd_addr];
      rd_stake_r <= mem_stake[rd_addr];
    end
  end

  // Walk conditions.
  assign full         = (count_r == CW'(N));
  assign scan_hit     = vld_r && (rd_id_r >= id_r);
  assign scan_match   = scan_hit && (rd_id_r == id_r);
  assign scan_end     = !vld_r && (idx_r == count_r);
  assign pick_end_sum = start_r + SUM_W'(rd_stake_r);
  assign pick_hit     = vld_r && (rd_stake_r != '0) && (SUM_W'(val_r) < pick_end_sum);
  assign scan_stop    = mode_r ? (!any_r || pick_hit || scan_end) : (scan_hit || scan_end);
  assign shift_done   = !vld_r && (idx_r == ins_r);
  assign pos_inc      = pos_r + CW'(1);
  assign idx_dec      = idx_r - CW'(1);

  // Stake update for an existing leader, saturating.
  assign upd_sum   = {1'b0, rd_stake_r} + (SW + 1)'(amt_r);
  assign upd_sat   = upd_sum[SW];
  assign upd_stake = upd_sat ? swlp_pkg::STAKE_MAX : upd_sum[SW-1:0];
  assign upd_delta = upd_sat ? (swlp_pkg::STAKE_MAX - rd_stake_r) : SW'(amt_r);

  assign total_sat = (total_r > SUM_W'(swlp_pkg::STAKE_MAX)) ? swlp_pkg::STAKE_MAX
                                                             : total_r[SW-1:0];

  // Status toward the controller.
  always_comb begin
    sts.is_pick    = mode_r;
    sts.scan_stop  = scan_stop;
    sts.scan_match = scan_match;
    sts.full       = full;
    sts.shift_done = shift_done;
    sts.out_free   = !out_valid_r || out_tready;
  end

  // Next-value logic for each command.
  always_comb begin
    count_nxt     = count_r;
    total_nxt     = total_r;
    any_nxt       = any_r;
    first_nxt     = first_r;
    last_nxt      = last_r;
    mode_nxt      = mode_r;
    id_nxt        = id_r;
    amt_nxt       = amt_r;
    val_nxt       = val_r;
    idx_nxt       = idx_r;
    pos_nxt       = pos_r;
    ins_nxt       = ins_r;
    vld_nxt       = vld_r;
    start_nxt     = start_r;
    seen_nxt      = seen_r;
    chosen_nxt    = chosen_r;
    status_nxt    = status_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_tready;
    rd_en         = 1'b0;
    rd_addr       = idx_r[AW-1:0];
    wr_en         = 1'b0;
    wr_addr       = pos_r[AW-1:0];
    wr_id         = rd_id_r;
    wr_stake      = rd_stake_r;
    leader_up     = 1'b0;

    case (cmd)
      swlp_pkg::CMD_LOAD: begin
        mode_nxt   = in_mode;
        id_nxt     = in_id;
        amt_nxt    = in_amt;
        val_nxt    = in_val;
        idx_nxt    = '0;
        vld_nxt    = 1'b0;
        start_nxt  = '0;
        seen_nxt   = '0;
        chosen_nxt = '0;
        status_nxt = swlp_pkg::STS_OK;
      end
      swlp_pkg::CMD_SCAN: begin
        if (scan_stop) begin
          vld_nxt = 1'b0;
          if (mode_r) begin
            // Pick finished: empty table, range hit or past the total.
            if (!any_r) begin
              chosen_nxt = '0;
              status_nxt = swlp_pkg::STS_EMPTY;
            end else if (pick_hit) begin
              chosen_nxt = rd_id_r;
            end else begin
              chosen_nxt = seen_r;
            end
          end else if (!scan_match) begin
            // New leader: drop it if full, else prepare the shift.
            if (full) begin
              status_nxt = swlp_pkg::STS_FULL;
            end else begin
              ins_nxt = scan_hit ? pos_r : count_r;
              idx_nxt = count_r;
            end
          end
        end else begin
          if (mode_r && vld_r && (rd_stake_r != '0)) begin
            seen_nxt  = rd_id_r;
            start_nxt = pick_end_sum;
          end
          if (idx_r != count_r) begin
            rd_en   = 1'b1;
            rd_addr = idx_r[AW-1:0];
            pos_nxt = idx_r;
            idx_nxt = idx_r + CW'(1);
            vld_nxt = 1'b1;
          end else begin
            vld_nxt = 1'b0;
          end
        end
      end
      swlp_pkg::CMD_SHIFT: begin
        // Move entries up one slot, from the top down to the insert point.
        if (vld_r) begin
          wr_en   = 1'b1;
          wr_addr = pos_inc[AW-1:0];
        end
        if (idx_r != ins_r) begin
          rd_en   = 1'b1;
          rd_addr = idx_dec[AW-1:0];
          pos_nxt = idx_dec;
          idx_nxt = idx_dec;
          vld_nxt = 1'b1;
        end else begin
          vld_nxt = 1'b0;
        end
      end
      swlp_pkg::CMD_UPDATE: begin
        wr_en      = 1'b1;
        wr_addr    = pos_r[AW-1:0];
        wr_id      = id_r;
        wr_stake   = upd_stake;
        total_nxt  = total_r + SUM_W'(upd_delta);
        status_nxt = upd_sat ? swlp_pkg::STS_SAT : swlp_pkg::STS_OK;
        leader_up  = (upd_stake != '0);
      end
      swlp_pkg::CMD_INSERT: begin
        wr_en      = 1'b1;
        wr_addr    = ins_r[AW-1:0];
        wr_id      = id_r;
        wr_stake   = SW'(amt_r);
        count_nxt  = count_r + CW'(1);
        total_nxt  = total_r + SUM_W'(amt_r);
        status_nxt = swlp_pkg::STS_OK;
        leader_up  = (amt_r != '0);
      end
      swlp_pkg::CMD_EMIT: begin
        out_data_nxt  = {{PAD_W{1'b0}}, status_r, last_r, first_r, total_sat, chosen_r};
        out_valid_nxt = 1'b1;
      end
      default: begin
      end
    endcase

    // Track the lowest and highest ids with nonzero stake.
    if (leader_up) begin
      any_nxt   = 1'b1;
      first_nxt = (!any_r || (id_r < first_r)) ? id_r : first_r;
      last_nxt  = (!any_r || (id_r > last_r)) ? id_r : last_r;
    end
  end

  // Control and table state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      total_r     <= '0;
      any_r       <= 1'b0;
      first_r     <= '0;
      last_r      <= '0;
      vld_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      total_r     <= total_nxt;
      any_r       <= any_nxt;
      first_r     <= first_nxt;
      last_r      <= last_nxt;
      vld_r       <= vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    id_r       <= id_nxt;
    amt_r      <= amt_nxt;
    val_r      <= val_nxt;
    idx_r      <= idx_nxt;
    pos_r      <= pos_nxt;
    ins_r      <= ins_nxt;
    start_r    <= start_nxt;
    seen_r     <= seen_nxt;
    chosen_r   <= chosen_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Table writes stay inside the filled region plus one slot.
  `SWLP_ASSERT_IMP(a_wr_in_range, wr_en, (CW'(wr_addr) <= count_r), "table write past fill")
  // A new leader is never inserted into a full table.
  `SWLP_ASSERT_IMP(a_ins_not_full, (cmd == swlp_pkg::CMD_INSERT), !full, "insert into full table")
  // The first nonzero-stake leader never sorts above the last one.
  `SWLP_ASSERT_IMP(a_ends_order, any_r, (first_r <= last_r), "first leader above last leader")
  // A nonzero total means some leader holds stake.
  `SWLP_ASSERT_IMP(a_total_any, (total_r != '0), any_r, "total without a staked leader")

endmodule

// ----- src/stake_weighted_leader_pick_core.sv -----
// Stake-weighted leader pick. The block holds up to MAX_LEADERS leaders in a
// table sorted by id, with one read port and one write port, and takes one item
// at a time. An add item walks the table one entry per cycle to find the id,
// then updates the stake in place, drops a new leader when the table is
// full, or shifts the upper entries up one slot per cycle and writes the
// new leader. A pick item walks the cumulative stake ranges one entry per
// cycle and stops at the range that holds the value; past the total it
// returns the last staked leader, and on an empty table it reports empty.
// The total and the first and last staked leaders are kept in registers, so
// every result reports them without another walk. A finished result waits in
// an output register while the next item is accepted. The table needs no
// clearing pass after reset; only the fill count, the total, the first and
// last leader tracking and the valid flags are cleared.
module stake_weighted_leader_pick_core #(
  parameter int MAX_LEADERS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  // leader_id[15:0], stake_amount[47:16], pick_value[87:48]
  input  logic [swlp_pkg::IN_DATA_W-1:0]      in_tdata,
  // mode[0]
  input  logic                                in_tuser,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  // chosen_leader[15:0], total_stake[55:16], first_leader[71:56],
  // last_leader[87:72], status[89:88], zero fill[95:90]
  output logic [swlp_pkg::OUT_DATA_W-1:0]     out_tdata
);

  swlp_pkg::cmd_t    cmd;
  swlp_pkg::dp_sts_t sts;

  // Sequencer.
  swlp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // Table, walk logic and result register.
  swlp_dp #(
    .MAX_LEADERS (MAX_LEADERS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_mode    (in_tuser),
    .in_id      (in_tdata[15:0]),
    .in_amt     (in_tdata[47:16]),
    .in_val     (in_tdata[87:48]),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata),
    .sts        (sts)
  );

endmodule

// ----- verif/tb_top.sv -----
`timescale 1ns / 1ps

localparam int unsigned LEADER_SLOTS = 64;

// Mode carried in tuser.
localparam logic MODE_ADD  = 1'b0;
localparam logic MODE_PICK = 1'b1;

// Field types of one beat.
typedef logic [swlp_pkg::ID_W-1:0]    leader_id_t;
typedef logic [swlp_pkg::AMT_W-1:0]   stake_amt_t;
typedef logic [swlp_pkg::STAKE_W-1:0] stake_t;

// One result beat, laid out as on out_tdata without the zero fill.
typedef struct packed {
  logic [1:0] status;
  leader_id_t last;
  leader_id_t first;
  stake_t     total;
  leader_id_t chosen;
} leader_result_t;

// Keeps its own sorted leader table, predicts the result of every accepted
// input beat and checks result beats against those predictions in order.
class leader_pick_scoreboard;
  leader_id_t     slot_id[LEADER_SLOTS];
  stake_t         slot_stake[LEADER_SLOTS];
  int unsigned    fill;
  stake_t         total;
  leader_result_t expected_q[$];
  int unsigned    errors;

  function new();
    fill = 0;
    total = '0;
    errors = 0;
  endfunction

  // Start of a slot's range on the unsaturated stake line.
  function logic [63:0] range_start(int unsigned upto);
    logic [63:0] acc;
    int unsigned i;
    acc = '0;
    for (i = 0; i < upto && i < fill; i++) acc += 64'(slot_stake[i]);
    return acc;
  endfunction

  // Adds stake to an existing leader or inserts a new one in id order.
  function logic [1:0] add_stake(leader_id_t id, stake_amt_t amount);
    int unsigned pos;
    int unsigned k;
    logic [swlp_pkg::STAKE_W:0] sum;
    pos = 0;
    while (pos < fill && slot_id[pos] < id) pos++;
    if (pos < fill && slot_id[pos] == id) begin
      sum = {1'b0, slot_stake[pos]} + {1'b0, stake_t'(amount)};
      if (sum[swlp_pkg::STAKE_W]) begin
        slot_stake[pos] = swlp_pkg::STAKE_MAX;
        return swlp_pkg::STS_SAT;
      end
      slot_stake[pos] = sum[swlp_pkg::STAKE_W-1:0];
      return swlp_pkg::STS_OK;
    end
    if (fill >= LEADER_SLOTS) return swlp_pkg::STS_FULL;
    for (k = fill; k > pos; k--) begin
      slot_id[k] = slot_id[k-1];
      slot_stake[k] = slot_stake[k-1];
    end
    slot_id[pos] = id;
    slot_stake[pos] = stake_t'(amount);
    fill++;
    return swlp_pkg::STS_OK;
  endfunction

  function void note_input(logic mode, leader_id_t id, stake_amt_t amount, stake_t value);
    leader_result_t r;
    logic [63:0] start;
    logic [63:0] line_end;
    logic hit;
    logic seen;
    int unsigned i;
    r = '0;
    if (mode == MODE_ADD) begin
      r.status = add_stake(id, amount);
      line_end = range_start(fill);
      total = (line_end > 64'(swlp_pkg::STAKE_MAX)) ? swlp_pkg::STAKE_MAX
                                                    : line_end[swlp_pkg::STAKE_W-1:0];
    end else if (total == '0) begin
      r.status = swlp_pkg::STS_EMPTY;
    end else begin
      // Walk the nonzero ranges; without a hit the last staked leader stays.
      start = '0;
      hit = 1'b0;
      for (i = 0; i < fill && !hit; i++) begin
        if (slot_stake[i] != '0) begin
          r.chosen = slot_id[i];
          if (64'(value) >= start && 64'(value) < start + 64'(slot_stake[i])) hit = 1'b1;
          else start += 64'(slot_stake[i]);
        end
      end
    end
    r.total = total;
    // First and last leaders that hold stake.
    seen = 1'b0;
    for (i = 0; i < fill; i++) begin
      if (slot_stake[i] != '0) begin
        if (!seen) r.first = slot_id[i];
        seen = 1'b1;
        r.last = slot_id[i];
      end
    end
    expected_q.push_back(r);
  endfunction

  function void compare(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  function void check_result(logic [swlp_pkg::OUT_DATA_W-1:0] beat);
    leader_result_t want;
    if (expected_q.size() == 0) begin
      errors++;
      $display("%0t: result beat with nothing expected, expected none, actual %h",
               $time, beat);
      return;
    end
    want = expected_q.pop_front();
    compare("chosen_leader", 64'(want.chosen), 64'(beat[15:0]));
    compare("total_stake",   64'(want.total),  64'(beat[55:16]));
    compare("first_leader",  64'(want.first),  64'(beat[71:56]));
    compare("last_leader",   64'(want.last),   64'(beat[87:72]));
    compare("status",        64'(want.status), 64'(beat[89:88]));
  endfunction
endclass

module tb_top;

  localparam int unsigned CYCLE_LIMIT    = 1500000;
  localparam int unsigned DRAIN_CYCLES   = 2 * LEADER_SLOTS + 16;
  localparam int unsigned HOLDOFF_AT     = 300;
  localparam int unsigned HOLDOFF_CYCLES = 800;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [swlp_pkg::IN_DATA_W-1:0]  in_tdata;
  logic                            in_tuser;
  logic                            out_tvalid;
  logic                            out_tready;
  logic [swlp_pkg::OUT_DATA_W-1:0] out_tdata;

  leader_pick_scoreboard sb;
  int unsigned           in_beats = 0;
  int unsigned           cycle_count = 0;
  int unsigned           quiet_left = 0;

  stake_weighted_leader_pick_core #(
    .MAX_LEADERS(LEADER_SLOTS)
  ) i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // 2 ns clock.
  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Result monitor.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  function automatic stake_t rand40();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[swlp_pkg::STAKE_W-1:0];
  endfunction

  function automatic stake_amt_t rand_amount();
    int unsigned r;
    r = $urandom_range(99, 0);
    if (r < 5) return '0;
    if (r < 45) return $urandom_range(1000, 1);
    if (r < 85) return $urandom;
    return '1;
  endfunction

  // Pick value aimed at range boundaries, inside the line or past its end.
  function automatic stake_t pick_target();
    logic [63:0] line_end;
    logic [63:0] mark;
    line_end = sb.range_start(sb.fill);
    case ($urandom_range(5, 0))
      0: mark = 64'(rand40());
      1, 2: mark = (line_end != 0) ? {$urandom, $urandom} % line_end : 64'd0;
      3: begin
        mark = sb.range_start($urandom_range(sb.fill, 0));
        if ($urandom_range(1, 0)) mark = mark - 64'd1;
      end
      4: mark = line_end + 64'($urandom_range(3, 0));
      default: mark = $urandom_range(1, 0) ? 64'(swlp_pkg::STAKE_MAX) : 64'd0;
    endcase
    return (mark > 64'(swlp_pkg::STAKE_MAX)) ? swlp_pkg::STAKE_MAX
                                             : mark[swlp_pkg::STAKE_W-1:0];
  endfunction

  function automatic leader_id_t known_id();
    if (sb.fill == 0) return leader_id_t'($urandom);
    return sb.slot_id[$urandom_range(sb.fill - 1, 0)];
  endfunction

  // Offers one beat from the falling edge and holds it until accepted.
  task automatic send_beat(input logic mode, input leader_id_t id,
                           input stake_amt_t amount, input stake_t value);
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {value, amount, id};
    do @(posedge clk); while (!in_tready);
    sb.note_input(mode, id, amount, value);
    in_beats++;
  endtask

  // Sender idles between beats, with occasional stretches of no idling.
  task automatic sender_gap();
    int unsigned n;
    int unsigned r;
    n = 0;
    r = $urandom_range(99, 0);
    if (quiet_left > 0) quiet_left--;
    else if (r < 3) quiet_left = 40;
    else if (r < 60) n = 0;
    else if (r < 92) n = $urandom_range(3, 1);
    else n = $urandom_range(60, 10);
    if (n > 0) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
      repeat (n - 1) @(negedge clk);
    end
  endtask

  task automatic issue(input logic mode, input leader_id_t id,
                       input stake_amt_t amount, input stake_t value);
    send_beat(mode, id, amount, value);
    sender_gap();
  endtask

  // Result side: random ready runs, plus one long hold-off while input keeps coming.
  initial begin : result_sink
    int unsigned run;
    logic level;
    logic held;
    held = 1'b0;
    out_tready = 1'b0;
    forever begin
      if (!held && in_beats >= HOLDOFF_AT) begin
        held = 1'b1;
        level = 1'b0;
        run = HOLDOFF_CYCLES;
      end else if ($urandom_range(3, 0) != 0) begin
        level = 1'b1;
        run = $urandom_range(40, 1);
      end else begin
        level = 1'b0;
        run = ($urandom_range(9, 0) == 0) ? $urandom_range(80, 20) : $urandom_range(3, 1);
      end
      @(negedge clk);
      out_tready <= level;
      repeat (run - 1) @(negedge clk);
    end
  end

  initial begin : stimulus
    leader_id_t id_pool[$];
    leader_id_t hot_id;
    stake_t     line_top;
    int unsigned n;
    sb = new();
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = MODE_ADD;
    rst_n     = 1'b0;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty picks, zero stake, range edges, values past the total.
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, swlp_pkg::STAKE_MAX);
    issue(MODE_ADD, 16'h8000, '0, rand40());
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, '0);
    issue(MODE_ADD, 16'hFFFF, '1, rand40());
    issue(MODE_ADD, 16'h0000, 32'd1, rand40());
    issue(MODE_ADD, 16'h8000, 32'd5, rand40());
    issue(MODE_ADD, 16'h1234, '0, rand40());
    line_top = 40'd6 + 40'hFFFF_FFFF;
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, 40'd0);
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, 40'd1);
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, 40'd5);
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, 40'd6);
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, line_top - 40'd1);
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, line_top);
    issue(MODE_PICK, leader_id_t'($urandom), $urandom, swlp_pkg::STAKE_MAX);
    issue(MODE_ADD, 16'hFFFF, '1, rand40());
    issue(MODE_ADD, 16'h0001, 32'hAAAA_AAAA, 40'hAA_AAAA_AAAA);
    issue(MODE_ADD, 16'hFFFE, 32'h5555_5555, 40'h55_5555_5555);
    issue(MODE_ADD, 16'hAAAA, 32'h0000_0001, rand40());
    issue(MODE_ADD, 16'h5555, 32'h8000_0000, rand40());
    issue(MODE_PICK, 16'hAAAA, 32'hAAAA_AAAA, 40'hAA_AAAA_AAAA);
    issue(MODE_PICK, 16'h5555, 32'h5555_5555, 40'h55_5555_5555);

    // Phase one: a pool of ids that grows the table, mixed with picks.
    id_pool = '{16'h0000, 16'hFFFF, 16'h0001, 16'hFFFE};
    repeat (36) id_pool.push_back(leader_id_t'($urandom));
    repeat (450) begin
      if ($urandom_range(99, 0) < 55)
        issue(MODE_ADD, id_pool[$urandom_range(id_pool.size() - 1, 0)], rand_amount(),
              rand40());
      else
        issue(MODE_PICK, leader_id_t'($urandom), $urandom, pick_target());
    end

    // Phase two: fresh ids fill the table, after which new leaders are dropped.
    repeat (350) begin
      n = $urandom_range(99, 0);
      if (n < 60) issue(MODE_ADD, leader_id_t'($urandom), rand_amount(), rand40());
      else if (n < 70) issue(MODE_ADD, known_id(), rand_amount(), rand40());
      else issue(MODE_PICK, leader_id_t'($urandom), $urandom, pick_target());
    end

    // Phase three: pile full amounts on one leader until its stake and the total clamp.
    hot_id = known_id();
    repeat (500) begin
      n = $urandom_range(99, 0);
      if (n < 64) issue(MODE_ADD, hot_id, '1, rand40());
      else if (n < 75) issue(MODE_ADD, known_id(), rand_amount(), rand40());
      else issue(MODE_PICK, leader_id_t'($urandom), $urandom, pick_target());
    end

    // Phase four: unshaped noise.
    repeat (250) issue(1'($urandom_range(1, 0)), leader_id_t'($urandom), $urandom, rand40());

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
